// ===== hdl/reciprocal_frequency_counter_assert.svh =====
// ----------------------------------------------------------------------------
// reciprocal frequency counter assertion macros
// ----------------------------------------------------------------------------
`ifndef RECIPROCAL_FREQUENCY_COUNTER_ASSERT_SVH
`define RECIPROCAL_FREQUENCY_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RFC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define RFC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// shared widths, constants and digit packing for the frequency counter
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

  localparam int CAPTURE_WIDTH = 16;
  localparam int REF_WIDTH     = 24;
  localparam int DIGIT_W       = 4;
  localparam int OUT_DIGITS    = 7;
  localparam int BCD_W         = OUT_DIGITS * DIGIT_W;
  localparam int TDATA_W       = ((BCD_W + 7) / 8) * 8;
  localparam int STEP_W        = $clog2(REF_WIDTH);

  localparam logic [REF_WIDTH-1:0] REF_RESET   = REF_WIDTH'(1000000);
  // largest value seven digits can show
  localparam logic [REF_WIDTH-1:0] DIGIT_LIMIT = REF_WIDTH'(9999999);
  localparam logic [STEP_W-1:0]    LAST_STEP   = STEP_W'(REF_WIDTH - 1);

  // bcd holds units in the low nibble; the word carries millions lowest
  function automatic logic [TDATA_W-1:0] pack_digits(input logic [BCD_W-1:0] bcd);
    logic [TDATA_W-1:0] w;
    w = '0;
    for (int j = 0; j < OUT_DIGITS; j++) begin
      w[DIGIT_W*(OUT_DIGITS-1-j) +: DIGIT_W] = bcd[DIGIT_W*j +: DIGIT_W];
    end
    return w;
  endfunction

  function automatic logic digits_ok(input logic [TDATA_W-1:0] w);
    logic ok;
    ok = 1'b1;
    for (int j = 0; j < OUT_DIGITS; j++) begin
      if (w[DIGIT_W*j +: DIGIT_W] > DIGIT_W'(9)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/reciprocal_frequency_counter.sv =====
// ----------------------------------------------------------------------------
// reciprocal_frequency_counter
// frequency from pairs of timer captures, as seven decimal digits
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one timer capture per word. captures pair up: the first
//   of a pair is stored, the second gives one result word on m_axis.
//   result = reference_count / (second - first mod 2^16), saturated to
//   9999999, as digits millions first in the low nibble of m_axis_tdata.
//   equal captures give all-zero digits and m_axis_tuser high.
//   cfg writes reference_count; cfg_ready is always high, write only idle.
// flow:
//   a second capture starts the bit-serial divider; its saturated quotient
//   then goes through the bcd converter and into the output register.
//   s_axis_tready is low meanwhile, so the next capture is not taken before
//   the result is loaded. equal captures skip the divider and converter
//   and go straight to the output register.
// reset:
//   reference_count returns to 1000000, the pair phase to the first edge.
// stall:
//   a finished result sits in the output register; the block takes the next
//   first capture meanwhile and holds a new result until the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module reciprocal_frequency_counter
  import rfc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // capture_value [15:0]
  input  wire logic [CAPTURE_WIDTH-1:0] s_axis_tdata,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // millions, hundred_thousands, ten_thousands, thousands, hundreds, tens,
  // units digit, 4 bits each from bit 0, zero fill above
  output logic [TDATA_W-1:0]            m_axis_tdata,
  // zero_period [0]
  output logic                          m_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  input  wire logic [REF_WIDTH-1:0]     cfg_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_BCD  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]               state;
  logic [REF_WIDTH-1:0]     reference_count;
  logic [CAPTURE_WIDTH-1:0] first_capture;
  logic                     second_edge_pending;
  logic                     res_zero;
  logic [CAPTURE_WIDTH-1:0] period;
  logic                     in_take;
  logic                     out_load;
  logic                     div_start;
  logic                     div_done;
  logic [REF_WIDTH-1:0]     quotient;
  logic [REF_WIDTH-1:0]     quot_sat;
  logic                     bcd_done;
  logic [BCD_W-1:0]         bcd;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign period        = s_axis_tdata - first_capture;
  assign div_start     = in_take && second_edge_pending && (period != '0);
  assign quot_sat      = (quotient > DIGIT_LIMIT) ? DIGIT_LIMIT : quotient;
  assign out_load      = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  rfc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (reference_count),
    .divisor  (period),
    .done     (div_done),
    .quotient (quotient)
  );

  rfc_bcd u_bcd (
    .clk   (clk),
    .rst   (rst),
    .start (div_done),
    .bin   (quot_sat),
    .done  (bcd_done),
    .bcd   (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_count <= REF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reference_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      first_capture       <= '0;
      second_edge_pending <= 1'b0;
      res_zero            <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (!second_edge_pending) begin
              first_capture       <= s_axis_tdata;
              second_edge_pending <= 1'b1;
            end else begin
              second_edge_pending <= 1'b0;
              res_zero            <= (period == '0);
              state               <= (period == '0) ? ST_OUT : ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_BCD;
          end
        end
        ST_BCD: begin
          if (bcd_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= res_zero ? '0 : pack_digits(bcd);
      m_axis_tuser <= res_zero;
    end
  end

`include "reciprocal_frequency_counter_assert.svh"

  `RFC_ASSERT_NOW(a_zero_digits, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "zero period word carries nonzero digits")
  `RFC_ASSERT_NOW(a_digits_dec, clk, rst, m_axis_tvalid, digits_ok(m_axis_tdata), "result digit above nine")
  `RFC_ASSERT_NEXT(a_pair_busy, clk, rst, in_take && second_edge_pending, !s_axis_tready && !second_edge_pending, "second capture did not start a result")
  `RFC_ASSERT_NOW(a_div_idle, clk, rst, div_done, state == ST_DIV, "divider finished outside divide phase")

endmodule

`default_nettype wire

// ===== hdl/rfc_div.sv =====
// ----------------------------------------------------------------------------
// rfc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_div
  import rfc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [REF_WIDTH-1:0]     dividend,
  input  wire logic [CAPTURE_WIDTH-1:0] divisor,
  output logic                          done,
  output logic [REF_WIDTH-1:0]          quotient
);

  logic                      busy;
  logic [STEP_W-1:0]         step;
  logic [CAPTURE_WIDTH-1:0]  rem;
  logic [CAPTURE_WIDTH-1:0]  dvs;
  logic [REF_WIDTH-1:0]      qsh;
  logic [CAPTURE_WIDTH+1:0]  trial;
  logic                      fits;

  // shifted partial remainder minus divisor, borrow in the top bit
  always_comb begin
    trial = {1'b0, rem, qsh[REF_WIDTH-1]} - {2'b00, dvs};
    fits  = ~trial[CAPTURE_WIDTH+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      qsh <= dividend;
    end else if (busy) begin
      rem <= fits ? trial[CAPTURE_WIDTH-1:0] : {rem[CAPTURE_WIDTH-2:0], qsh[REF_WIDTH-1]};
      qsh <= {qsh[REF_WIDTH-2:0], fits};
    end
  end

  assign quotient = qsh;

endmodule

`default_nettype wire

// ===== hdl/rfc_bcd.sv =====
// ----------------------------------------------------------------------------
// rfc_bcd
// binary to bcd by shift and add-3, one binary bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_bcd
  import rfc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [REF_WIDTH-1:0] bin,
  output logic                      done,
  output logic [BCD_W-1:0]          bcd
);

  logic                 busy;
  logic [STEP_W-1:0]    step;
  logic [REF_WIDTH-1:0] bsh;
  logic [BCD_W-1:0]     adj;

  always_comb begin
    for (int j = 0; j < OUT_DIGITS; j++) begin
      adj[DIGIT_W*j +: DIGIT_W] = (bcd[DIGIT_W*j +: DIGIT_W] >= DIGIT_W'(5))
                                  ? bcd[DIGIT_W*j +: DIGIT_W] + DIGIT_W'(3)
                                  : bcd[DIGIT_W*j +: DIGIT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == LAST_STEP);
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // top digit bits that overflow are dropped, input is saturated upstream
  always_ff @(posedge clk) begin
    if (start) begin
      bcd <= '0;
      bsh <= bin;
    end else if (busy) begin
      bcd <= {adj[BCD_W-2:0], bsh[REF_WIDTH-1]};
      bsh <= {bsh[REF_WIDTH-2:0], 1'b0};
    end
  end

endmodule

`default_nettype wire

// ===== test/tb_reciprocal_frequency_counter.sv =====
// ----------------------------------------------------------------------------
// tb_reciprocal_frequency_counter
// The stream side gets timer captures in pairs, and the second capture of a
// pair is checked against a local model of the counter. That model covers the
// wrap-around period, the divide, saturation and the zero-period flag. First
// a directed table runs through the extremes and special cases. Then random
// pairs run under several reference counts, with random gaps on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_reciprocal_frequency_counter
  import rfc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DRAIN_CYCLES = 64;
  localparam int unsigned SHOW_LIMIT   = 9_999_999;
  localparam int          PHASES       = 6;
  localparam int          PAIRS        = 75;

  // digits in reading order: millions in the top nibble, units lowest
  typedef struct packed {
    logic             zero_period;
    logic [BCD_W-1:0] digits;
  } freq_word_t;

  typedef enum logic {ROW_CAPTURE, ROW_SET_REF} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [REF_WIDTH-1:0] value;
    logic                 typed;
    freq_word_t           want;
  } directed_row_t;

  logic                     clk;
  logic                     rst;
  logic [CAPTURE_WIDTH-1:0] s_axis_tdata;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [TDATA_W-1:0]       m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [REF_WIDTH-1:0]     cfg_data;
  logic                     cfg_valid;
  logic                     cfg_ready;

  // counter model state
  logic [REF_WIDTH-1:0]     ref_ticks = REF_RESET;
  logic [CAPTURE_WIDTH-1:0] first_stamp = '0;
  logic                     pair_open = 1'b0;

  freq_word_t    expected_freqs [$];
  directed_row_t directed_rows [$];
  int            mismatch_count = 0;
  logic          steady_flow = 1'b0;

  reciprocal_frequency_counter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data      (cfg_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("reciprocal_frequency_counter verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s: got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // updates the pair state; returns 1 when the capture closes a pair
  function automatic bit predict_capture(input logic [CAPTURE_WIDTH-1:0] stamp,
                                         output freq_word_t w);
    logic [CAPTURE_WIDTH-1:0] period;
    int unsigned              quotient;
    w = '0;
    if (!pair_open) begin
      first_stamp = stamp;
      pair_open   = 1'b1;
      return 1'b0;
    end
    pair_open = 1'b0;
    period    = stamp - first_stamp;
    if (period == '0) begin
      w.zero_period = 1'b1;
      return 1'b1;
    end
    quotient = int'(ref_ticks) / int'(period);
    if (quotient > SHOW_LIMIT) quotient = SHOW_LIMIT;
    for (int k = 0; k < OUT_DIGITS; k++) begin
      w.digits[DIGIT_W*k +: DIGIT_W] = DIGIT_W'(quotient % 10);
      quotient = quotient / 10;
    end
    return 1'b1;
  endfunction

  task automatic send_capture(input logic [CAPTURE_WIDTH-1:0] stamp,
                              input logic typed = 1'b0,
                              input freq_word_t typed_word = '0);
    freq_word_t predicted;
    while (!steady_flow && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= stamp;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (predict_capture(stamp, predicted)) begin
      expected_freqs.push_back(typed ? typed_word : predicted);
    end
  endtask

  // reference count only changes once every result is out
  task automatic set_reference(input logic [REF_WIDTH-1:0] ticks);
    s_axis_tvalid <= 1'b0;
    while (expected_freqs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_data  <= ticks;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    ref_ticks = ticks;
  endtask

  task automatic send_random_pair();
    logic [CAPTURE_WIDTH-1:0] start_stamp;
    logic [CAPTURE_WIDTH-1:0] span;
    start_stamp = CAPTURE_WIDTH'($urandom);
    case ($urandom_range(9))
      0: span = '0;
      1, 2, 3: span = CAPTURE_WIDTH'($urandom_range(1, 64));
      4: span = CAPTURE_WIDTH'(16'hFFFF - $urandom_range(0, 15));
      default: span = CAPTURE_WIDTH'($urandom);
    endcase
    send_capture(start_stamp);
    send_capture(start_stamp + span);
  endtask

  function automatic logic [REF_WIDTH-1:0] phase_reference(input int phase);
    case (phase)
      0: return REF_WIDTH'(1_000_000);
      1: return REF_WIDTH'(1);
      2: return REF_WIDTH'(9_999_999);
      3: return REF_WIDTH'($urandom_range(2, 9_999_998));
      4: return {REF_WIDTH{1'b1}};
      default: return REF_WIDTH'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  task automatic add_row(input row_kind_t kind, input logic [REF_WIDTH-1:0] value,
                         input logic typed = 1'b0, input logic zp = 1'b0,
                         input logic [BCD_W-1:0] digits = '0);
    directed_row_t row;
    row.kind             = kind;
    row.value            = value;
    row.typed            = typed;
    row.want.zero_period = zp;
    row.want.digits      = digits;
    directed_rows.push_back(row);
  endtask

  task automatic check_result(input logic [TDATA_W-1:0] word, input logic zp);
    freq_word_t want;
    if (expected_freqs.size() == 0) begin
      report_mismatch("result word with none pending", word, 0);
      return;
    end
    want = expected_freqs.pop_front();
    // dut word carries millions in the low nibble
    for (int j = 0; j < OUT_DIGITS; j++) begin
      if (word[DIGIT_W*j +: DIGIT_W] !== want.digits[DIGIT_W*(OUT_DIGITS-1-j) +: DIGIT_W]) begin
        report_mismatch($sformatf("10^%0d digit", OUT_DIGITS-1-j),
                        word[DIGIT_W*j +: DIGIT_W],
                        want.digits[DIGIT_W*(OUT_DIGITS-1-j) +: DIGIT_W]);
      end
    end
    if ((word >> BCD_W) !== '0) begin
      report_mismatch("tdata fill bits", word >> BCD_W, 0);
    end
    if (zp !== want.zero_period) begin
      report_mismatch("zero_period", zp, want.zero_period);
    end
  endtask

  // result side: check on handshake, then pick the next ready
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata, m_axis_tuser);
      end
      m_axis_tready <= steady_flow || ($urandom_range(99) >= 36);
    end
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tdata  <= '0;
    s_axis_tvalid <= 1'b0;
    cfg_data      <= '0;
    cfg_valid     <= 1'b0;

    // reset reference count first, digits written millions to units
    add_row(ROW_CAPTURE, 24'h0000);
    add_row(ROW_CAPTURE, 24'h0001, 1'b1, 1'b0, 28'h1000000);
    add_row(ROW_CAPTURE, 24'hFFFF);
    add_row(ROW_CAPTURE, 24'h0000, 1'b1, 1'b0, 28'h1000000);  // period wraps to one tick
    add_row(ROW_CAPTURE, 24'h1234);
    add_row(ROW_CAPTURE, 24'h1234, 1'b1, 1'b1, 28'h0000000);  // equal captures
    add_row(ROW_CAPTURE, 24'h0000);
    add_row(ROW_CAPTURE, 24'hFFFF, 1'b1, 1'b0, 28'h0000015);  // longest period
    add_row(ROW_CAPTURE, 24'hFFFF);
    add_row(ROW_CAPTURE, 24'hFFFE, 1'b1, 1'b0, 28'h0000015);
    add_row(ROW_CAPTURE, 24'hAAAA);
    add_row(ROW_CAPTURE, 24'h5555);
    add_row(ROW_SET_REF, 24'd9999999);
    add_row(ROW_CAPTURE, 24'd100);
    add_row(ROW_CAPTURE, 24'd101, 1'b1, 1'b0, 28'h9999999);
    // above the stated range: quotient saturates
    add_row(ROW_SET_REF, 24'hFFFFFF);
    add_row(ROW_CAPTURE, 24'd5);
    add_row(ROW_CAPTURE, 24'd6, 1'b1, 1'b0, 28'h9999999);
    add_row(ROW_SET_REF, 24'd0);
    add_row(ROW_CAPTURE, 24'd7);
    add_row(ROW_CAPTURE, 24'd8, 1'b1, 1'b0, 28'h0000000);
    add_row(ROW_CAPTURE, 24'd9);
    add_row(ROW_CAPTURE, 24'd9, 1'b1, 1'b1, 28'h0000000);
    add_row(ROW_SET_REF, 24'd1);
    add_row(ROW_CAPTURE, 24'd0);
    add_row(ROW_CAPTURE, 24'd2, 1'b1, 1'b0, 28'h0000000);
    add_row(ROW_CAPTURE, 24'd3);
    add_row(ROW_CAPTURE, 24'd4, 1'b1, 1'b0, 28'h0000001);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_SET_REF) begin
        set_reference(directed_rows[r].value);
      end else begin
        send_capture(CAPTURE_WIDTH'(directed_rows[r].value), directed_rows[r].typed,
                     directed_rows[r].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      set_reference(phase_reference(phase));
      for (int p = 0; p < PAIRS; p++) begin
        steady_flow <= (phase == 2 && p >= 10 && p < 70);
        send_random_pair();
      end
    end
    s_axis_tvalid <= 1'b0;
    steady_flow   <= 1'b0;

    while (expected_freqs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("reciprocal_frequency_counter verification clean");
    end else begin
      $display("reciprocal_frequency_counter verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
